>>> hdl/psnct_pkg.sv
// Shared types, constants and helper functions of the palette shade table block.
package psnct_pkg;

  localparam int PAL_ENTRIES = 256;
  localparam int PAL_AW      = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;
  localparam logic [PAL_AW-1:0] PAL_LAST = PAL_AW'(PAL_ENTRIES - 1);

  localparam int TBL_DEPTH = 256;
  localparam int TBL_AW    = 8;

  localparam int KEY_W = 16;
  localparam logic [KEY_W-1:0] KEY_INIT = 16'hFFFF;

  // Command codes.
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_BUILD = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Result kinds.
  localparam logic KIND_BUILD = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_BRIGHT = 2'd0;
  localparam logic [1:0] REG_DELTA  = 2'd1;
  localparam logic [1:0] REG_MASK   = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] entry_index;
    logic [5:0] red_in;
    logic [5:0] green_in;
    logic [5:0] blue_in;
  } cmd_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] entry_echo;
    logic [7:0] mapped_index;
  } rsp_t;

  typedef struct packed {
    logic [5:0] bright_limit;
    logic [6:0] shade_delta;
    logic [2:0] channel_mask;
  } shade_cfg_t;

  // Palette write: red in bits 5:0, green in 11:6, blue in 17:12.
  typedef struct packed {
    logic              we;
    logic [PAL_AW-1:0] addr;
    logic [17:0]       color;
  } pal_wr_t;

  typedef struct packed {
    logic              we;
    logic [TBL_AW-1:0] addr;
    logic [7:0]        data;
  } tbl_wr_t;

  function automatic logic [5:0] max3(input logic [5:0] a, input logic [5:0] b,
                                      input logic [5:0] c);
    logic [5:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic logic [5:0] absdiff6(input logic [5:0] a, input logic [5:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // A part is lowered only when it is selected and at least the delta.
  function automatic logic [5:0] shade_part(input logic [5:0] part, input logic en,
                                            input logic [6:0] delta);
    return (en && ({1'b0, part} >= delta)) ? (part - delta[5:0]) : part;
  endfunction

endpackage

>>> hdl/psnct_table.sv
// Translation table: 256 x 8 memory with per-entry valid bits, registered read.
module psnct_table
  import psnct_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  tbl_wr_t           wr,
  input  logic              rd_en,
  input  logic [TBL_AW-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0]           mem [TBL_DEPTH];
  logic [TBL_DEPTH-1:0] valid;
  logic [7:0]           rd_mem;
  logic                 rd_hit;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_mem <= mem[rd_addr];
    end
  end

  // An entry that was never built reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (wr.we) begin
        valid[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_hit ? rd_mem : 8'd0;

endmodule

>>> hdl/psnct_search.sv
// Palette memory and the build sequencer that runs the nearest-color search.
module psnct_search
  import psnct_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  shade_cfg_t cfg,
  input  pal_wr_t    pal_wr,
  output tbl_wr_t    tbl_wr,
  output logic       done
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WAIT  = 5'b00010,
    S_PIX   = 5'b00100,
    S_SCAN  = 5'b01000,
    S_DRAIN = 5'b10000
  } state_t;

  state_t            state;
  logic [17:0]       mem [PAL_ENTRIES];
  logic [17:0]       rdata;
  logic [PAL_AW-1:0] addr;
  logic [PAL_AW-1:0] n;

  logic              rd_ok;
  logic [PAL_AW-1:0] rd_k;
  logic              key_ok;
  logic [KEY_W-1:0]  key;
  logic [PAL_AW-1:0] key_k;
  logic [KEY_W-1:0]  best_key;
  logic [PAL_AW-1:0] best_at;

  logic [5:0]        p_r, p_g, p_b;
  logic [5:0]        sh_r, sh_g, sh_b;
  logic [KEY_W-1:0]  key_next;
  logic              drained;

  always_ff @(posedge clk) begin
    if (pal_wr.we) begin
      mem[pal_wr.addr] <= pal_wr.color;
    end
    rdata <= mem[addr];
  end

  // Darkened color of the entry being mapped; rdata holds that entry in S_PIX.
  always_comb begin
    logic [5:0] r, g, b;
    logic       dark;
    r    = rdata[5:0];
    g    = rdata[11:6];
    b    = rdata[17:12];
    dark = max3(r, g, b) >= cfg.bright_limit;
    sh_r = dark ? shade_part(r, cfg.channel_mask[0], cfg.shade_delta) : r;
    sh_g = dark ? shade_part(g, cfg.channel_mask[1], cfg.shade_delta) : g;
    sh_b = dark ? shade_part(b, cfg.channel_mask[2], cfg.shade_delta) : b;
  end

  // Distance in the upper byte, largest part as tie break below it.
  always_comb begin
    logic [5:0] q0, q1, q2;
    logic [7:0] span;
    q0       = rdata[5:0];
    q1       = rdata[11:6];
    q2       = rdata[17:12];
    span     = 8'(absdiff6(q0, p_r)) + 8'(absdiff6(q1, p_g)) + 8'(absdiff6(q2, p_b));
    key_next = {span, 2'b00, max3(q0, q1, q2)};
  end

  assign drained = !rd_ok && !key_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rd_ok  <= 1'b0;
      key_ok <= 1'b0;
      addr   <= '0;
      n      <= '0;
    end else begin
      rd_ok  <= (state == S_SCAN);
      key_ok <= rd_ok;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            n     <= '0;
            addr  <= '0;
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          state <= S_PIX;
        end
        S_PIX: begin
          addr  <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          addr <= addr + 1'b1;
          if (addr == PAL_LAST) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (drained) begin
            if (n == PAL_LAST) begin
              state <= S_IDLE;
            end else begin
              n     <= n + 1'b1;
              addr  <= n + 1'b1;
              state <= S_WAIT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_k  <= addr;
    key   <= key_next;
    key_k <= rd_k;
    if (state == S_PIX) begin
      p_r      <= sh_r;
      p_g      <= sh_g;
      p_b      <= sh_b;
      best_key <= KEY_INIT;
      best_at  <= '0;
    end else if (key_ok && (key < best_key)) begin
      best_key <= key;
      best_at  <= key_k;
    end
  end

  assign tbl_wr.we   = (state == S_DRAIN) && drained;
  assign tbl_wr.addr = TBL_AW'(n);
  assign tbl_wr.data = 8'(best_at);
  assign done        = (state == S_DRAIN) && drained && (n == PAL_LAST);

endmodule

>>> hdl/palette_shade_nearest_color_table_core.sv
// Top level of the palette shade table: command decode, configuration and result register.
//
// Commands arrive on cmd (cmd_valid / cmd_stall); results leave on rsp
// (rsp_valid / rsp_stall). A beat moves when valid is high and stall is low.
// Configuration registers are written through cfg_en, cfg_addr and cfg_wdata;
// the user must write them while the block is idle; the block does not enforce this.
//
// A palette write gives no result. A table read gives one result, registered
// in the table read stage and then in the result register; outside a build,
// reads can be accepted every cycle unless a stalled receiver holds the read
// stage and the result register. A build walks every palette entry against
// every palette entry through one read port of the palette memory, each table
// entry passing through S_WAIT, S_PIX, S_SCAN and S_DRAIN of psnct_search.
// cmd_stall stays high from the build beat until its result has been loaded
// into the result register.
//
// Reset clears the registers, the result register and the table valid bits,
// so every table entry reads as zero until a build writes it. Palette
// entries hold no reset value and must be written before a build.
module palette_shade_nearest_color_table_core
  import psnct_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  cmd_t       cmd,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output rsp_t       rsp,
  input  logic       cfg_en,
  input  logic [1:0] cfg_addr,
  input  logic [6:0] cfg_wdata
);

  typedef enum logic [2:0] {
    ST_RUN    = 3'b001,
    ST_BUILD  = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t     state;
  shade_cfg_t cfg;
  pal_wr_t    pal_wr;
  tbl_wr_t    tbl_wr;
  logic       cmd_acc;
  logic       out_ready;
  logic       start;
  logic       done;
  logic       rd_en;
  logic       rd_valid;
  logic [7:0] rd_echo;
  logic [7:0] tbl_rdata;

  assign out_ready = !rsp_valid || !rsp_stall;

  always_comb begin
    cmd_stall = (state != ST_RUN) || (rd_valid && !out_ready);
  end

  assign cmd_acc = cmd_valid && !cmd_stall;
  assign start   = cmd_acc && (cmd.command == CMD_BUILD);
  assign rd_en   = cmd_acc && (cmd.command == CMD_READ);

  // Writes beyond the palette are dropped.
  assign pal_wr.we    = cmd_acc && (cmd.command == CMD_WRITE) &&
                        ({1'b0, cmd.entry_index} < 9'(PAL_ENTRIES));
  assign pal_wr.addr  = cmd.entry_index[PAL_AW-1:0];
  assign pal_wr.color = {cmd.blue_in, cmd.green_in, cmd.red_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_en) begin
      unique case (cfg_addr)
        REG_BRIGHT: cfg.bright_limit <= cfg_wdata[5:0];
        REG_DELTA:  cfg.shade_delta  <= cfg_wdata;
        REG_MASK:   cfg.channel_mask <= cfg_wdata[2:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      unique case (state)
        ST_RUN:    if (start) state <= ST_BUILD;
        ST_BUILD:  if (done) state <= ST_FINISH;
        ST_FINISH: if (out_ready) state <= ST_RUN;
        default:   state <= ST_RUN;
      endcase
    end
  end

  psnct_search u_search (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cfg    (cfg),
    .pal_wr (pal_wr),
    .tbl_wr (tbl_wr),
    .done   (done)
  );

  psnct_table u_table (
    .clk     (clk),
    .rst     (rst),
    .wr      (tbl_wr),
    .rd_en   (rd_en),
    .rd_addr (cmd.entry_index),
    .rd_data (tbl_rdata)
  );

  // Read stage: holds a read whose table data waits for the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (rd_en) begin
      rd_valid <= 1'b1;
    end else if (out_ready) begin
      rd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_echo <= cmd.entry_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rd_valid && out_ready) begin
      rsp_valid        <= 1'b1;
      rsp.result_kind  <= KIND_READ;
      rsp.entry_echo   <= rd_echo;
      rsp.mapped_index <= tbl_rdata;
    end else if ((state == ST_FINISH) && out_ready) begin
      rsp_valid        <= 1'b1;
      rsp.result_kind  <= KIND_BUILD;
      rsp.entry_echo   <= 8'd0;
      rsp.mapped_index <= 8'd0;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

>>> hdl/psnct_checker.sv
// Port-level checks of the palette shade table, bound to the top level.
module psnct_checker
  import psnct_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_stall,
  input cmd_t       cmd,
  input logic       rsp_valid,
  input logic       rsp_stall,
  input rsp_t       rsp
);

  logic cmd_beat;
  assign cmd_beat = cmd_valid && !cmd_stall;

  // A stalled result beat holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result beat changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid right after reset");

  // A build blocks further commands while it runs.
  a_build_blocks: assert property (@(posedge clk) disable iff (rst)
    cmd_beat && (cmd.command == CMD_BUILD) |=> cmd_stall)
    else $error("command taken right after a build beat");

  // With no older result in the way, a read answers through the read stage and the result register with its index.
  a_read_answer: assert property (@(posedge clk) disable iff (rst)
    cmd_beat && (cmd.command == CMD_READ) ##1 !rsp_valid
    |=> rsp_valid && (rsp.result_kind == KIND_READ) &&
        (rsp.entry_echo == $past(cmd.entry_index, 2)))
    else $error("read result missing or wrong entry");

endmodule

bind palette_shade_nearest_color_table_core psnct_checker u_psnct_checker (.*);

>>> sim/palette_shade_nearest_color_table_core_tb.sv
// Self-checking testbench for the palette shade table core with a shadow model of the table.
`timescale 1ns / 1ps

module palette_shade_nearest_color_table_core_tb;
  import psnct_pkg::*;

  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 130;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD = 300;
  localparam int FLOOD_READS = 24;
  localparam int CYCLE_LIMIT = 2_500_000;

  typedef enum logic [1:0] {PIN_OFF, PIN_SILENT, PIN_REPLY} pin_mode_t;

  typedef struct packed {
    cmd_t      beat;
    pin_mode_t pin;
    rsp_t      reply;
  } drill_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cmd_valid = 1'b0;
  logic       cmd_stall;
  cmd_t       cmd_beat = '0;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  rsp_t       rsp_beat;
  logic       cfg_en = 1'b0;
  logic [1:0] cfg_addr = '0;
  logic [6:0] cfg_wdata = '0;

  // Shadow copy of the block state.
  logic [17:0] shadow_palette [PAL_ENTRIES];
  logic [7:0]  shadow_map [TBL_DEPTH];
  shade_cfg_t  shade_now = '0;

  rsp_t       table_replies [$];
  drill_row_t drill_rows [$];
  pin_mode_t  pin_mode = PIN_OFF;
  rsp_t       pin_reply = '0;
  int         mismatch_count = 0;
  int         holds_asked = 0;
  int         holds_served = 0;
  bit         sender_idles = 1'b1;

  palette_shade_nearest_color_table_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd_beat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp_beat),
    .cfg_en    (cfg_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int part_max(input int a, input int b, input int c);
    int m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // Smallest Manhattan distance wins; ties go to the smaller largest part, then the lower index.
  function automatic logic [7:0] nearest_color(input int r, input int g, input int b);
    int best_key;
    int best_at;
    int key;
    int span;
    int q0, q1, q2;
    int k;
    best_key = 'hFFFF;
    best_at = 0;
    for (k = 0; k < PAL_ENTRIES; k++) begin
      q0 = int'(shadow_palette[k][5:0]);
      q1 = int'(shadow_palette[k][11:6]);
      q2 = int'(shadow_palette[k][17:12]);
      span = ((q0 > r) ? q0 - r : r - q0) + ((q1 > g) ? q1 - g : g - q1)
           + ((q2 > b) ? q2 - b : b - q2);
      key = ((span & 'hFF) << 8) | part_max(q0, q1, q2);
      if (key < best_key) begin
        best_key = key;
        best_at = k;
      end
    end
    return 8'(best_at);
  endfunction

  function automatic void build_map();
    int p [3];
    int n, c;
    for (n = 0; n < PAL_ENTRIES; n++) begin
      for (c = 0; c < 3; c++) p[c] = int'(shadow_palette[n][6*c +: 6]);
      if (part_max(p[0], p[1], p[2]) >= int'(shade_now.bright_limit)) begin
        for (c = 0; c < 3; c++) begin
          if (shade_now.channel_mask[c] && p[c] >= int'(shade_now.shade_delta))
            p[c] -= int'(shade_now.shade_delta);
        end
      end
      shadow_map[n] = nearest_color(p[0], p[1], p[2]);
    end
  endfunction

  // Applies one accepted beat to the shadow state; returns 1 when it owes a reply.
  function automatic bit play_command(input cmd_t c, output rsp_t r);
    r = '0;
    case (c.command)
      CMD_WRITE: begin
        if (int'(c.entry_index) < PAL_ENTRIES)
          shadow_palette[c.entry_index] = {c.blue_in, c.green_in, c.red_in};
        return 1'b0;
      end
      CMD_BUILD: begin
        build_map();
        r.result_kind = KIND_BUILD;
        return 1'b1;
      end
      CMD_READ: begin
        r.result_kind = KIND_READ;
        r.entry_echo = c.entry_index;
        r.mapped_index = shadow_map[c.entry_index];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Mix of full-range parts and a few clustered values so that ties show up.
  function automatic logic [5:0] pick_part();
    if ($urandom_range(0, 1) == 0) return 6'($urandom_range(0, 63));
    case ($urandom_range(0, 7))
      0: return 6'd0;
      1: return 6'd1;
      2: return 6'd2;
      3: return 6'd31;
      4: return 6'd32;
      5: return 6'd33;
      6: return 6'd62;
      default: return 6'd63;
    endcase
  endfunction

  function automatic cmd_t random_beat();
    cmd_t c;
    int pick;
    c.entry_index = 8'($urandom_range(0, 255));
    c.red_in = pick_part();
    c.green_in = pick_part();
    c.blue_in = pick_part();
    pick = $urandom_range(0, 99);
    if (pick < 55) c.command = CMD_READ;
    else if (pick < 95) c.command = CMD_WRITE;
    else c.command = CMD_SPARE;
    return c;
  endfunction

  function automatic int next_gap();
    int pick;
    if (!sender_idles) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic void add_row(input logic [1:0] op, input logic [7:0] idx,
                                  input logic [5:0] r, input logic [5:0] g,
                                  input logic [5:0] b, input pin_mode_t pin,
                                  input logic kind, input logic [7:0] echo,
                                  input logic [7:0] mapped);
    drill_row_t row;
    row.beat = '{op, idx, r, g, b};
    row.pin = pin;
    row.reply = '{kind, echo, mapped};
    drill_rows.insert(drill_rows.size(), row);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Valid stays high after the beat so that a following beat can go out back to back.
  task automatic push_beat(input cmd_t c, input int gap, input pin_mode_t pin,
                           input rsp_t pinned);
    @(negedge clk);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_beat <= c;
    pin_mode = pin;
    pin_reply = pinned;
    do @(posedge clk); while (cmd_stall !== 1'b0);
  endtask

  // A palette write leaves no reply behind, so a settle wait after the replies covers it.
  task automatic wait_drained();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (table_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_register(input logic [1:0] idx, input logic [6:0] val);
    @(negedge clk);
    cfg_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_en <= 1'b0;
    case (idx)
      REG_BRIGHT: shade_now.bright_limit = val[5:0];
      REG_DELTA:  shade_now.shade_delta = val;
      REG_MASK:   shade_now.channel_mask = val[2:0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : track_block
    rsp_t owed;
    bit   makes_reply;
    if (!rst) begin
      if (cmd_valid && cmd_stall === 1'b0) begin
        makes_reply = play_command(cmd_beat, owed);
        if (pin_mode == PIN_REPLY) table_replies.insert(table_replies.size(), pin_reply);
        else if (pin_mode == PIN_OFF && makes_reply)
          table_replies.insert(table_replies.size(), owed);
      end
      if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
        if (table_replies.size() == 0) begin
          report_mismatch($sformatf("reply kind %0d entry %0d index %0d with none owed",
                                    rsp_beat.result_kind, rsp_beat.entry_echo,
                                    rsp_beat.mapped_index));
        end else begin
          owed = table_replies.pop_front();
          if (rsp_beat.result_kind !== owed.result_kind)
            report_mismatch($sformatf("result_kind got %0d want %0d",
                                      rsp_beat.result_kind, owed.result_kind));
          if (rsp_beat.entry_echo !== owed.entry_echo)
            report_mismatch($sformatf("entry_echo got %0d want %0d",
                                      rsp_beat.entry_echo, owed.entry_echo));
          if (rsp_beat.mapped_index !== owed.mapped_index)
            report_mismatch($sformatf("mapped_index got %0d want %0d (entry %0d)",
                                      rsp_beat.mapped_index, owed.mapped_index,
                                      owed.entry_echo));
        end
      end
    end
  end

  // Receiver pacing: free runs, short and long stalls, and the long hold on request.
  initial begin : rsp_pacing
    int run;
    int pick;
    @(negedge clk);
    forever begin
      if (holds_served != holds_asked) begin
        rsp_stall <= 1'b1;
        holds_served++;
        run = LONG_HOLD;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          rsp_stall <= 1'b0;
          run = $urandom_range(1, 8);
        end else if (pick < 60) begin
          rsp_stall <= 1'b0;
          run = $urandom_range(20, 60);
        end else if (pick < 92) begin
          rsp_stall <= 1'b1;
          run = $urandom_range(1, 3);
        end else begin
          rsp_stall <= 1'b1;
          run = $urandom_range(8, 30);
        end
      end
      repeat (run) @(negedge clk);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("palette_shade_nearest_color_table_core test failed");
    $finish;
  end

  initial begin : stimulus
    cmd_t c;
    int   i, ph, build_at;
    for (i = 0; i < PAL_ENTRIES; i++) shadow_palette[i] = '0;
    for (i = 0; i < TBL_DEPTH; i++) shadow_map[i] = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // An unused register index must not disturb the real ones.
    set_register(REG_SPARE, 7'h7F);

    // Every palette entry is loaded before any build reads it.
    for (i = 0; i < PAL_ENTRIES; i++) begin
      c = random_beat();
      c.command = CMD_WRITE;
      c.entry_index = 8'(i);
      push_beat(c, next_gap(), PIN_OFF, '0);
    end

    // The table reads zero until the first build, whatever the palette holds.
    add_row(CMD_READ, 8'd0, 6'd0, 6'd0, 6'd0, PIN_REPLY, KIND_READ, 8'd0, 8'd0);
    add_row(CMD_READ, 8'd255, 6'd63, 6'd63, 6'd63, PIN_REPLY, KIND_READ, 8'd255, 8'd0);
    add_row(CMD_READ, 8'd170, 6'd42, 6'd21, 6'd42, PIN_REPLY, KIND_READ, 8'd170, 8'd0);
    add_row(CMD_SPARE, 8'd255, 6'd63, 6'd63, 6'd63, PIN_SILENT, KIND_BUILD, 8'd0, 8'd0);
    add_row(CMD_SPARE, 8'd0, 6'd0, 6'd0, 6'd0, PIN_SILENT, KIND_BUILD, 8'd0, 8'd0);
    add_row(CMD_WRITE, 8'd0, 6'd0, 6'd0, 6'd0, PIN_SILENT, KIND_BUILD, 8'd0, 8'd0);
    add_row(CMD_WRITE, 8'd255, 6'd63, 6'd63, 6'd63, PIN_SILENT, KIND_BUILD, 8'd0, 8'd0);
    add_row(CMD_WRITE, 8'd1, 6'd63, 6'd0, 6'd0, PIN_SILENT, KIND_BUILD, 8'd0, 8'd0);
    add_row(CMD_WRITE, 8'd2, 6'd0, 6'd63, 6'd0, PIN_SILENT, KIND_BUILD, 8'd0, 8'd0);
    add_row(CMD_WRITE, 8'd3, 6'd0, 6'd0, 6'd63, PIN_SILENT, KIND_BUILD, 8'd0, 8'd0);
    // Same color as entry 255, so the tie goes to the lower index.
    add_row(CMD_WRITE, 8'd4, 6'd63, 6'd63, 6'd63, PIN_SILENT, KIND_BUILD, 8'd0, 8'd0);
    add_row(CMD_WRITE, 8'd5, 6'd21, 6'd42, 6'd21, PIN_SILENT, KIND_BUILD, 8'd0, 8'd0);
    add_row(CMD_WRITE, 8'd6, 6'd42, 6'd21, 6'd42, PIN_SILENT, KIND_BUILD, 8'd0, 8'd0);
    add_row(CMD_READ, 8'd85, 6'd21, 6'd42, 6'd21, PIN_REPLY, KIND_READ, 8'd85, 8'd0);
    add_row(CMD_BUILD, 8'd0, 6'd0, 6'd0, 6'd0, PIN_REPLY, KIND_BUILD, 8'd0, 8'd0);
    add_row(CMD_READ, 8'd255, 6'd0, 6'd0, 6'd0, PIN_OFF, KIND_READ, 8'd0, 8'd0);
    add_row(CMD_READ, 8'd0, 6'd63, 6'd63, 6'd63, PIN_OFF, KIND_READ, 8'd0, 8'd0);
    add_row(CMD_READ, 8'd1, 6'd0, 6'd0, 6'd0, PIN_OFF, KIND_READ, 8'd0, 8'd0);
    add_row(CMD_READ, 8'd4, 6'd0, 6'd0, 6'd0, PIN_OFF, KIND_READ, 8'd0, 8'd0);
    add_row(CMD_READ, 8'd5, 6'd0, 6'd0, 6'd0, PIN_OFF, KIND_READ, 8'd0, 8'd0);
    add_row(CMD_READ, 8'd6, 6'd0, 6'd0, 6'd0, PIN_OFF, KIND_READ, 8'd0, 8'd0);
    add_row(CMD_READ, 8'd85, 6'd0, 6'd0, 6'd0, PIN_OFF, KIND_READ, 8'd0, 8'd0);
    foreach (drill_rows[i])
      push_beat(drill_rows[i].beat, next_gap(), drill_rows[i].pin, drill_rows[i].reply);

    for (ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          set_register(REG_BRIGHT, 7'd63);
          set_register(REG_DELTA, 7'd127);
          set_register(REG_MASK, 7'd7);
        end
        1: begin
          set_register(REG_BRIGHT, 7'd0);
          set_register(REG_DELTA, 7'd63);
          set_register(REG_MASK, 7'd7);
        end
        2: begin
          set_register(REG_BRIGHT, 7'd0);
          set_register(REG_DELTA, 7'd1);
          set_register(REG_MASK, 7'd1);
        end
        3: begin
          set_register(REG_BRIGHT, 7'd32);
          set_register(REG_DELTA, 7'd16);
          set_register(REG_MASK, 7'd6);
        end
        default: begin
          set_register(REG_BRIGHT, 7'($urandom_range(0, 127)));
          set_register(REG_DELTA, 7'($urandom_range(0, 127)));
          set_register(REG_MASK, 7'($urandom_range(0, 127)));
        end
      endcase

      build_at = $urandom_range(PHASE_ITEMS / 4, 3 * PHASE_ITEMS / 4);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 40 == 0) sender_idles = ($urandom_range(0, 2) != 0);
        // Let every owed reply come back before going on.
        if (ph == 4 && i == 60) wait_drained();
        if (i == build_at) begin
          c = random_beat();
          c.command = CMD_BUILD;
          push_beat(c, next_gap(), PIN_OFF, '0);
        end else if (ph == 2 && i == 20) begin
          // Reads keep coming during a long receiver hold until the input stalls.
          @(negedge clk);
          cmd_valid <= 1'b0;
          holds_asked++;
          wait (holds_served == holds_asked);
          repeat (FLOOD_READS) begin
            c = random_beat();
            c.command = CMD_READ;
            push_beat(c, 0, PIN_OFF, '0);
          end
        end else begin
          push_beat(random_beat(), next_gap(), PIN_OFF, '0);
        end
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && table_replies.size() == 0) begin
      $display("palette_shade_nearest_color_table_core test passed");
    end else begin
      $display("palette_shade_nearest_color_table_core test failed");
    end
    $finish;
  end

endmodule
